// ----- rtl/core/upd_pkg.sv -----
package upd_pkg;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // one classified input transaction: 1 to 3 output bytes, in order b0, b1, b2
    typedef struct packed {
        logic [1:0] cnt;
        logic       last;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_entry;

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        begin
            r = ((c >= 8'h30) && (c <= 8'h39)) ||
                ((c >= 8'h61) && (c <= 8'h66)) ||
                ((c >= 8'h41) && (c <= 8'h46));
            return r;
        end
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        begin
            if ((c >= 8'h30) && (c <= 8'h39)) begin
                d = c - 8'h30;
            end else if ((c >= 8'h61) && (c <= 8'h66)) begin
                d = c - 8'h57;
            end else begin
                d = c - 8'h37;
            end
            return d[3:0];
        end
    endfunction

endpackage

// ----- rtl/core/upd_front.sv -----
module upd_front
    import upd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_push,
    output t_entry     o_entry
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;

    logic       hex;
    logic       plain_hold;
    logic [7:0] plain_byte;

    always_comb begin
        hex        = is_hex(i_byte);
        // a bare '%' that is not the final byte starts an escape
        plain_hold = (i_byte == CH_PCT) && !i_last;
        plain_byte = (i_byte == CH_PLUS) ? CH_SPACE : i_byte;

        n_phase      = r_phase;
        n_held       = r_held;
        o_entry.cnt  = 2'd0;
        o_entry.last = i_last;
        o_entry.b0   = plain_byte;
        o_entry.b1   = plain_byte;
        o_entry.b2   = plain_byte;

        case (r_phase)
            PH_PCT: begin
                if (hex && !i_last) begin
                    n_held  = i_byte;
                    n_phase = PH_DIGIT;
                end else begin
                    o_entry.b0  = CH_PCT;
                    o_entry.cnt = plain_hold ? 2'd1 : 2'd2;
                    n_phase     = plain_hold ? PH_PCT : PH_IDLE;
                end
            end
            PH_DIGIT: begin
                if (hex) begin
                    o_entry.b0  = {hex_val(r_held), hex_val(i_byte)};
                    o_entry.cnt = 2'd1;
                    n_phase     = PH_IDLE;
                end else begin
                    o_entry.b0  = CH_PCT;
                    o_entry.b1  = r_held;
                    o_entry.cnt = plain_hold ? 2'd2 : 2'd3;
                    n_phase     = plain_hold ? PH_PCT : PH_IDLE;
                end
            end
            default: begin
                o_entry.cnt = plain_hold ? 2'd0 : 2'd1;
                n_phase     = plain_hold ? PH_PCT : PH_IDLE;
            end
        endcase

        if (i_last) begin
            n_phase = PH_IDLE;
        end

        o_push = i_accept && (o_entry.cnt != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'h00;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

// ----- rtl/core/upd_fifo.sv -----
module upd_fifo
    import upd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_head,
    output logic   o_empty,
    output logic   o_full
);

    t_entry             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count out of range");

endmodule

// ----- rtl/core/upd_back.sv -----
module upd_back
    import upd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry     i_head,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_last,
    input  logic       i_stall
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic [1:0] r_idx;

    logic       load;
    logic       at_end;
    logic [7:0] sel_byte;

    always_comb begin
        load   = !r_valid || !i_stall;
        at_end = (r_idx == (i_head.cnt - 2'd1));
        case (r_idx)
            2'd0:    sel_byte = i_head.b0;
            2'd1:    sel_byte = i_head.b1;
            default: sel_byte = i_head.b2;
        endcase
        o_pop = load && !i_empty && at_end;
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_idx <= at_end ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_byte <= sel_byte;
            // only the final byte of a string-ending transaction carries the mark
            r_last <= i_head.last && at_end;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd3)
        else $error("byte index out of range");

    a_idx_reset_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_idx == 2'd0))
        else $error("index not cleared after pop");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> (r_valid && $stable(r_byte) && $stable(r_last)))
        else $error("output changed while stalled");

endmodule

// ----- rtl/core/url_percent_decoder.sv -----
// URL percent decoder for query-string bytes.
// Input channel: i_in_valid / o_in_stall carry one encoded character (i_in_byte)
// and a final-character mark (i_in_last). Output channel: o_out_valid /
// i_out_stall carry one decoded byte (o_out_byte) and o_out_last, set on the
// final decoded byte of a string.
// "%hh" (either case) becomes one byte, '+' becomes a space; a malformed or cut
// escape is passed through as '%' plus any held digit, then rescanned.
// The front stage decodes each accepted character combinationally and writes
// 1 to 3 bytes as one entry into a 4-entry queue, or nothing while an escape
// is pending; the back stage drains the queue byte by byte into the output
// register. A byte passes through the queue and then the output register (the
// result of an escape appears after its last hex digit). The input takes one
// character per cycle while o_in_stall is low, and the output one byte per
// cycle while i_out_stall is low, so a malformed escape producing 2 or 3 bytes
// leaves them one at a time; o_in_stall rises only once the queue is full.
// When the receiver stalls, the output holds its byte and the queue fills,
// then o_in_stall is raised. Reset clears the escape state, the queue and the
// output valid; no decoding pass or warm-up is needed.
module url_percent_decoder
    import upd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic   in_accept;
    logic   push;
    logic   pop;
    logic   empty;
    logic   full;
    t_entry entry;
    t_entry head;

    assign o_in_stall = full;
    assign in_accept  = i_in_valid && !full;

    upd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_in_byte),
        .i_last   (i_in_last),
        .o_push   (push),
        .o_entry  (entry)
    );

    upd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_empty  (empty),
        .o_full   (full)
    );

    upd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_valid  (o_out_valid),
        .o_byte   (o_out_byte),
        .o_last   (o_out_last),
        .i_stall  (i_out_stall)
    );

endmodule
